[rtl/websocket_frame_deframer_defines.svh]
// ----------------------------------------------------------------------------
// WebSocket frame deframer assertion macros
// Shared property macros for the concurrent checks of the deframer.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WSDF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WSDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/wsdf_pkg.sv]
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Shared widths, codes, state encoding and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package wsdf_pkg;

    localparam int LENGTH_BITS = 64;

    localparam logic [3:0] OPCODE_TEXT   = 4'd1;
    localparam logic [3:0] OPCODE_BINARY = 4'd2;
    localparam logic [3:0] OPCODE_CLOSE  = 4'd8;

    localparam logic [6:0] LEN_MAX_SHORT = 7'd125;
    localparam logic [6:0] LEN_EXT16     = 7'd126;

    localparam logic [2:0] EXT_BYTES_16 = 3'd2;
    // Eight extended bytes wrap to zero in three bits and count down through seven.
    localparam logic [2:0] EXT_BYTES_64 = 3'd0;

    localparam logic [2:0] SEEN_LIMIT = 3'd6;

    typedef enum logic [1:0] {
        KIND_BINARY = 2'd0,
        KIND_TEXT   = 2'd1,
        KIND_CLOSE  = 2'd2,
        KIND_OTHER  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_CONTROL = 2'd1,
        STATUS_CLOSE   = 2'd2,
        STATUS_INVALID = 2'd3
    } status_t;

    typedef enum logic [6:0] {
        PH_FLAGS   = 7'b0000001,
        PH_LEN     = 7'b0000010,
        PH_EXT     = 7'b0000100,
        PH_MASK    = 7'b0001000,
        PH_PAYLOAD = 7'b0010000,
        PH_CONTROL = 7'b0100000,
        PH_SKIP    = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic       emit;
        logic       has_data;
        logic [7:0] payload_byte;
        logic       frame_end;
        status_t    status;
        logic       text_frame;
    } result_t;

endpackage

`default_nettype wire

[rtl/wsdf_core.sv]
// ----------------------------------------------------------------------------
// WebSocket frame deframer parser core
// Holds the frame state and computes the next state and result of one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wsdf_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire logic [7:0]        data_byte,
    input  wire logic              chunk_end,
    output wsdf_pkg::result_t      result
);

    wsdf_pkg::phase_t                      phase_reg, phase_next;
    logic [2:0]                            ext_left_reg, ext_left_next;
    logic [wsdf_pkg::LENGTH_BITS-1:0]      remaining_reg, remaining_next;
    logic [31:0]                           mask_key_reg, mask_key_next;
    logic [1:0]                            mask_pos_reg, mask_pos_next;
    logic [2:0]                            seen_reg, seen_next;
    wsdf_pkg::kind_t                       kind_reg, kind_next;
    logic                                  outcome_reg, outcome_next;

    logic [3:0]  opcode;
    logic [6:0]  short_len;
    logic [7:0]  key_byte;
    logic [4:0]  key_sel;
    logic [wsdf_pkg::LENGTH_BITS-1:0] remaining_dec;

    assign opcode        = data_byte[3:0];
    assign short_len     = data_byte[6:0];
    assign key_sel       = {~mask_pos_reg, 3'b000};
    assign key_byte      = mask_key_reg[key_sel +: 8];
    assign remaining_dec = remaining_reg - wsdf_pkg::LENGTH_BITS'(1);

    always_comb
    begin
        phase_next     = phase_reg;
        ext_left_next  = ext_left_reg;
        remaining_next = remaining_reg;
        mask_key_next  = mask_key_reg;
        mask_pos_next  = mask_pos_reg;
        kind_next      = kind_reg;
        seen_next      = (seen_reg < wsdf_pkg::SEEN_LIMIT) ? seen_reg + 3'd1 : seen_reg;

        result.emit         = 1'b0;
        result.has_data     = 1'b0;
        result.payload_byte = 8'h00;
        result.frame_end    = 1'b0;
        result.status       = wsdf_pkg::STATUS_OK;

        case (phase_reg)
            wsdf_pkg::PH_FLAGS:
            begin
                if (opcode == wsdf_pkg::OPCODE_TEXT)
                begin
                    kind_next = wsdf_pkg::KIND_TEXT;
                end
                else if (opcode == wsdf_pkg::OPCODE_BINARY)
                begin
                    kind_next = wsdf_pkg::KIND_BINARY;
                end
                else if (opcode == wsdf_pkg::OPCODE_CLOSE)
                begin
                    kind_next = wsdf_pkg::KIND_CLOSE;
                end
                else
                begin
                    kind_next = wsdf_pkg::KIND_OTHER;
                end
                if (!data_byte[7])
                begin
                    result.emit      = 1'b1;
                    result.frame_end = 1'b1;
                    result.status    = wsdf_pkg::STATUS_INVALID;
                    phase_next       = wsdf_pkg::PH_SKIP;
                end
                else if (kind_next inside {wsdf_pkg::KIND_CLOSE, wsdf_pkg::KIND_OTHER})
                begin
                    phase_next = wsdf_pkg::PH_CONTROL;
                end
                else
                begin
                    phase_next = wsdf_pkg::PH_LEN;
                end
            end
            wsdf_pkg::PH_CONTROL:
            begin
                if (seen_next >= wsdf_pkg::SEEN_LIMIT)
                begin
                    result.emit      = 1'b1;
                    result.frame_end = 1'b1;
                    result.status    = (kind_reg == wsdf_pkg::KIND_CLOSE) ?
                                       wsdf_pkg::STATUS_CLOSE : wsdf_pkg::STATUS_CONTROL;
                    phase_next       = wsdf_pkg::PH_SKIP;
                end
            end
            wsdf_pkg::PH_LEN:
            begin
                mask_pos_next = 2'd0;
                if (short_len <= wsdf_pkg::LEN_MAX_SHORT)
                begin
                    remaining_next = {{(wsdf_pkg::LENGTH_BITS-7){1'b0}}, short_len};
                    phase_next     = wsdf_pkg::PH_MASK;
                end
                else
                begin
                    remaining_next = '0;
                    ext_left_next  = (short_len == wsdf_pkg::LEN_EXT16) ?
                                     wsdf_pkg::EXT_BYTES_16 : wsdf_pkg::EXT_BYTES_64;
                    phase_next     = wsdf_pkg::PH_EXT;
                end
            end
            wsdf_pkg::PH_EXT:
            begin
                if (remaining_reg[wsdf_pkg::LENGTH_BITS-1 -: 8] != 8'h00)
                begin
                    result.emit      = 1'b1;
                    result.frame_end = 1'b1;
                    result.status    = wsdf_pkg::STATUS_INVALID;
                    phase_next       = wsdf_pkg::PH_SKIP;
                end
                else
                begin
                    remaining_next = {remaining_reg[wsdf_pkg::LENGTH_BITS-9:0], data_byte};
                    ext_left_next  = ext_left_reg - 3'd1;
                    if (ext_left_next == 3'd0)
                    begin
                        phase_next = wsdf_pkg::PH_MASK;
                    end
                end
            end
            wsdf_pkg::PH_MASK:
            begin
                mask_key_next = {mask_key_reg[23:0], data_byte};
                mask_pos_next = mask_pos_reg + 2'd1;
                if (mask_pos_next == 2'd0)
                begin
                    if (remaining_reg == '0)
                    begin
                        result.emit      = 1'b1;
                        result.frame_end = 1'b1;
                        result.status    = wsdf_pkg::STATUS_OK;
                        phase_next       = wsdf_pkg::PH_SKIP;
                    end
                    else
                    begin
                        phase_next = wsdf_pkg::PH_PAYLOAD;
                    end
                end
            end
            wsdf_pkg::PH_PAYLOAD:
            begin
                result.emit         = 1'b1;
                result.has_data     = 1'b1;
                result.payload_byte = data_byte ^ key_byte;
                mask_pos_next       = mask_pos_reg + 2'd1;
                remaining_next      = remaining_dec;
                if (remaining_dec == '0)
                begin
                    result.frame_end = 1'b1;
                    result.status    = wsdf_pkg::STATUS_OK;
                    phase_next       = wsdf_pkg::PH_SKIP;
                end
            end
            default:
            begin
                phase_next = wsdf_pkg::PH_SKIP;
            end
        endcase

        outcome_next = outcome_reg | result.frame_end;

        if (chunk_end && !outcome_next)
        begin
            result.emit      = 1'b1;
            result.frame_end = 1'b1;
            result.status    = wsdf_pkg::STATUS_INVALID;
            outcome_next     = 1'b1;
        end

        result.text_frame = (kind_next == wsdf_pkg::KIND_TEXT);

        if (chunk_end)
        begin
            phase_next     = wsdf_pkg::PH_FLAGS;
            ext_left_next  = 3'd0;
            remaining_next = '0;
            mask_key_next  = 32'h0;
            mask_pos_next  = 2'd0;
            seen_next      = 3'd0;
            kind_next      = wsdf_pkg::KIND_BINARY;
            outcome_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= wsdf_pkg::PH_FLAGS;
            ext_left_reg  <= 3'd0;
            remaining_reg <= '0;
            mask_key_reg  <= 32'h0;
            mask_pos_reg  <= 2'd0;
            seen_reg      <= 3'd0;
            kind_reg      <= wsdf_pkg::KIND_BINARY;
            outcome_reg   <= 1'b0;
        end
        else if (take)
        begin
            phase_reg     <= phase_next;
            ext_left_reg  <= ext_left_next;
            remaining_reg <= remaining_next;
            mask_key_reg  <= mask_key_next;
            mask_pos_reg  <= mask_pos_next;
            seen_reg      <= seen_next;
            kind_reg      <= kind_next;
            outcome_reg   <= outcome_next;
        end
    end

endmodule

`default_nettype wire

[rtl/wsdf_out_reg.sv]
// ----------------------------------------------------------------------------
// WebSocket frame deframer result register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wsdf_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wsdf_pkg::result_t      result,
    output logic                   full,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   has_data,
    output logic [7:0]             payload_byte,
    output logic                   frame_end,
    output logic [1:0]             status,
    output logic                   text_frame
);

    logic              valid_reg, valid_next;
    wsdf_pkg::result_t data_reg;
    logic              drain;

    assign drain      = valid_reg && !out_stall;
    assign full       = valid_reg && out_stall;
    assign valid_next = (take && result.emit) || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && result.emit && (drain || !valid_reg))
        begin
            data_reg <= result;
        end
    end

    assign out_valid    = valid_reg;
    assign has_data     = data_reg.has_data;
    assign payload_byte = data_reg.payload_byte;
    assign frame_end    = data_reg.frame_end;
    assign status       = data_reg.status;
    assign text_frame   = data_reg.text_frame;

endmodule

`default_nettype wire

[rtl/websocket_frame_deframer.sv]
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses one masked frame per received chunk and returns unmasked payload
// bytes followed by a frame status.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  input   | in        | in_valid/in_stall  | data_byte, chunk_end
//  output  | out       | out_valid/out_stall| has_data, payload_byte, frame_end,
//          |           |                    | status, text_frame
//
// One byte is accepted per cycle while in_stall is low; any result of it
// appears in the output register on the next cycle. The parser state update
// and the mask XOR sit between the frame state and output registers. Reset
// clears the frame state and empties the output register. in_stall rises
// only while a result waits in the output register and out_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "websocket_frame_deframer_defines.svh"

module websocket_frame_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        chunk_end,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             has_data,
    output logic [7:0]       payload_byte,
    output logic             frame_end,
    output logic [1:0]       status,
    output logic             text_frame
);

    wsdf_pkg::result_t result;
    logic              take;
    logic              full;

    assign in_stall = full;
    assign take     = in_valid && !full;

    wsdf_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .chunk_end (chunk_end),
        .result    (result)
    );

    wsdf_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .result       (result),
        .full         (full),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .has_data     (has_data),
        .payload_byte (payload_byte),
        .frame_end    (frame_end),
        .status       (status),
        .text_frame   (text_frame)
    );

    `WSDF_ASSERT_SAME(a_held_blocks_input, out_valid && out_stall, in_stall,
        "held result must stall input")
    `WSDF_ASSERT_SAME(a_plain_is_data, out_valid && !frame_end, has_data,
        "result without frame end must carry data")
    `WSDF_ASSERT_SAME(a_status_only_at_end, out_valid && !frame_end,
        status == wsdf_pkg::STATUS_OK, "status set before frame end")
    `WSDF_ASSERT_NEXT(a_held_result_stays, out_valid && out_stall,
        out_valid && $stable({has_data, payload_byte, frame_end, status, text_frame}),
        "held result changed")

endmodule

`default_nettype wire
